@@ src/mrf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrf_pkg
// shared types, constants and sha-256 helpers for the merkle root fold
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam int HashWords = 4;
  localparam int WordW     = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD,
    BLK_SECOND
  } blk_t;

  localparam logic CMD_LEAF    = 1'b0;
  localparam logic CMD_SIBLING = 1'b1;

  localparam logic [255:0] INIT_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ src/merkle_root_fold_sha256d_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merkle_root_fold_sha256d_top
// merkle root fold with double sha-256 over a branch of sibling hashes
// ----------------------------------------------------------------------------
// usage: every hash travels as four 64-bit words, byte 0 in bits 63:56.
// command 0 loads a word of the starting leaf, command 1 a word of a sibling.
// sibling word 3 folds: current = sha256(sha256(current || sibling)).
// end_of_branch on word 3 emits the root as four out words, index 0..3,
// last_word on word 3.
// flow: a word that does not fold passes through load only. a fold runs three
// compressions on one shared round unit, each a load, 64 rounds and an add,
// and in_stall stays high until the fold is done. after end_of_branch the
// root words follow in index order.
// reset: rst_n low clears the running hash to zero and returns to idle.
// in_stall stays high while a word is being worked on or emitted; out_stall
// holds the current out word until it is taken.
// ----------------------------------------------------------------------------
module merkle_root_fold_sha256d_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [1:0]  in_word_index,
  input  logic [63:0] in_hash_word,
  input  logic        in_end_of_branch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_root_word,
  output logic [1:0]  out_root_word_index,
  output logic        out_last_word
);

  mrf_pkg::state_t state_r, state_nxt;
  mrf_pkg::blk_t   blk_r, blk_nxt;

  logic [255:0] cur_r, cur_nxt;
  logic [255:0] sib_r, sib_nxt;
  logic [255:0] h_r, h_nxt;
  logic [255:0] v_r, v_nxt;
  logic [511:0] w_r, w_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [1:0]   oidx_r, oidx_nxt;
  logic         emit_r, emit_nxt;

  logic         acc;
  logic [511:0] blk_words;
  logic [31:0]  a, b, c, d, e, f, g, hh, t1, t2, s0, s1, wnew, w15, w2;
  logic [255:0] sum;

  assign acc = in_valid && !in_stall;
  assign in_stall = (state_r != mrf_pkg::ST_IDLE);

  always_comb begin
    unique case (blk_r)
      mrf_pkg::BLK_DATA: blk_words = {cur_r, sib_r};
      mrf_pkg::BLK_PAD:  blk_words = {32'h80000000, 448'd0, 32'd512};
      default:           blk_words = {h_r, 32'h80000000, 192'd0, 32'd256};
    endcase
  end

  always_comb begin
    a = v_r[255:224]; b = v_r[223:192]; c = v_r[191:160]; d = v_r[159:128];
    e = v_r[127:96];  f = v_r[95:64];   g = v_r[63:32];   hh = v_r[31:0];
    t1 = hh + (mrf_pkg::rotr(e, 6) ^ mrf_pkg::rotr(e, 11) ^ mrf_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + mrf_pkg::round_k(rnd_r) + w_r[511:480];
    t2 = (mrf_pkg::rotr(a, 2) ^ mrf_pkg::rotr(a, 13) ^ mrf_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
    w15 = w_r[479:448];
    w2  = w_r[63:32];
    s0 = mrf_pkg::rotr(w15, 7) ^ mrf_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1 = mrf_pkg::rotr(w2, 17) ^ mrf_pkg::rotr(w2, 19) ^ (w2 >> 10);
    wnew = w_r[511:480] + s0 + w_r[223:192] + s1;
    for (int i = 0; i < 8; i++) begin
      sum[i*32 +: 32] = h_r[i*32 +: 32] + v_r[i*32 +: 32];
    end
  end

  always_comb begin
    state_nxt = state_r;
    blk_nxt   = blk_r;
    cur_nxt   = cur_r;
    sib_nxt   = sib_r;
    h_nxt     = h_r;
    v_nxt     = v_r;
    w_nxt     = w_r;
    rnd_nxt   = rnd_r;
    oidx_nxt  = oidx_r;
    emit_nxt  = emit_r;
    unique case (state_r)
      mrf_pkg::ST_IDLE: begin
        if (acc) begin
          emit_nxt = (in_word_index == 2'd3) && in_end_of_branch;
          oidx_nxt = 2'd0;
          if (in_command == mrf_pkg::CMD_LEAF) begin
            cur_nxt[(3 - in_word_index) * 64 +: 64] = in_hash_word;
            state_nxt = mrf_pkg::ST_LOAD;
          end else begin
            sib_nxt[(3 - in_word_index) * 64 +: 64] = in_hash_word;
            if (in_word_index == 2'd3) begin
              blk_nxt   = mrf_pkg::BLK_DATA;
              h_nxt     = mrf_pkg::INIT_H;
              state_nxt = mrf_pkg::ST_LOAD;
              rnd_nxt   = 6'd1;
            end else begin
              state_nxt = mrf_pkg::ST_LOAD;
            end
          end
        end
      end
      mrf_pkg::ST_LOAD: begin
        // rnd 1 marks the start of a compression, else plain word
        if (rnd_r == 6'd1) begin
          w_nxt     = blk_words;
          v_nxt     = h_r;
          rnd_nxt   = 6'd0;
          state_nxt = mrf_pkg::ST_ROUND;
        end else begin
          state_nxt = emit_r ? mrf_pkg::ST_EMIT : mrf_pkg::ST_IDLE;
        end
      end
      mrf_pkg::ST_ROUND: begin
        v_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
        w_nxt = {w_r[479:0], wnew};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = mrf_pkg::ST_ADD;
        end
      end
      mrf_pkg::ST_ADD: begin
        unique case (blk_r)
          mrf_pkg::BLK_DATA: begin
            h_nxt = sum; blk_nxt = mrf_pkg::BLK_PAD;
            rnd_nxt = 6'd1; state_nxt = mrf_pkg::ST_LOAD;
          end
          mrf_pkg::BLK_PAD: begin
            h_nxt = sum; blk_nxt = mrf_pkg::BLK_SECOND;
            rnd_nxt = 6'd1; state_nxt = mrf_pkg::ST_LOAD;
          end
          default: begin
            cur_nxt = sum;
            h_nxt = mrf_pkg::INIT_H;
            state_nxt = emit_r ? mrf_pkg::ST_EMIT : mrf_pkg::ST_IDLE;
          end
        endcase
      end
      mrf_pkg::ST_EMIT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            state_nxt = mrf_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = mrf_pkg::ST_IDLE;
    endcase
    // third block uses init h while holding previous digest in the block
    if (state_r == mrf_pkg::ST_LOAD && rnd_r == 6'd1 && blk_r == mrf_pkg::BLK_SECOND) begin
      v_nxt = mrf_pkg::INIT_H;
      h_nxt = mrf_pkg::INIT_H;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrf_pkg::ST_IDLE;
      cur_r   <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      emit_r  <= 1'b0;
      blk_r   <= mrf_pkg::BLK_DATA;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      emit_r  <= emit_nxt;
      blk_r   <= blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sib_r <= sib_nxt;
    h_r   <= h_nxt;
    v_r   <= v_nxt;
    w_r   <= w_nxt;
  end

  assign out_valid           = (state_r == mrf_pkg::ST_EMIT);
  assign out_root_word       = cur_r[(3 - oidx_r) * 64 +: 64];
  assign out_root_word_index = oidx_r;
  assign out_last_word       = (oidx_r == 2'd3);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != mrf_pkg::ST_IDLE) |-> !acc)
    else $error("word accepted while busy");
  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=> (out_valid &&
      out_root_word_index == $past(out_root_word_index) + 2'd1))
    else $error("root words out of order");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> (state_r == mrf_pkg::ST_IDLE))
    else $error("no return to idle after root");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrf_pkg::ST_ROUND && rnd_r == 6'd63) |=> (state_r == mrf_pkg::ST_ADD))
    else $error("round count overrun");

endmodule

@@ tb/merkle_root_fold_sha256d_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// merkle_root_fold_sha256d_top_tb
// self-checking bench for the merkle root fold: a local double sha-256
// predictor follows every accepted word and checks each root word in order,
// with random gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module merkle_root_fold_sha256d_top_tb;

  localparam bit [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam bit [31:0] StartH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    bit [63:0] word;
    bit [1:0]  idx;
    bit        last;
  } root_word_t;

  class root_scoreboard;
    bit [63:0]  running_hash [mrf_pkg::HashWords];
    bit [63:0]  sibling_words [mrf_pkg::HashWords];
    root_word_t expected_roots [$];
    int         errors;
    int         folds;
    int         roots;
    int         words_in;

    function bit [31:0] rr(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress(ref bit [31:0] h [8], input bit [31:0] blk [16]);
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
      end
      for (int i = 0; i < 8; i++) v[i] = h[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (rr(v[4], 6) ^ rr(v[4], 11) ^ rr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
        t2 = (rr(v[0], 2) ^ rr(v[0], 13) ^ rr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) h[i] = h[i] + v[i];
    endfunction

    function void fold_sibling();
      bit [31:0] blk [16];
      bit [31:0] h [8];
      for (int i = 0; i < mrf_pkg::HashWords; i++) begin
        blk[2*i]     = running_hash[i][63:32];
        blk[2*i+1]   = running_hash[i][31:0];
        blk[8+2*i]   = sibling_words[i][63:32];
        blk[8+2*i+1] = sibling_words[i][31:0];
      end
      h = StartH;
      compress(h, blk);
      foreach (blk[i]) blk[i] = '0;
      blk[0] = 32'h80000000;
      blk[15] = 32'd512;
      compress(h, blk);
      foreach (blk[i]) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[i] = h[i];
      blk[8] = 32'h80000000;
      blk[15] = 32'd256;
      h = StartH;
      compress(h, blk);
      for (int i = 0; i < mrf_pkg::HashWords; i++) running_hash[i] = {h[2*i], h[2*i+1]};
      folds++;
    endfunction

    function void note_word(bit cmd, bit [1:0] idx, bit [63:0] word, bit eob);
      root_word_t r;
      words_in++;
      if (cmd == mrf_pkg::CMD_LEAF) running_hash[idx] = word;
      else begin
        sibling_words[idx] = word;
        if (idx == 2'd3) fold_sibling();
      end
      if (idx == 2'd3 && eob) begin
        roots++;
        for (int k = 0; k < mrf_pkg::HashWords; k++) begin
          r.word = running_hash[k];
          r.idx  = k[1:0];
          r.last = (k == mrf_pkg::HashWords - 1);
          expected_roots.insert(expected_roots.size(), r);
        end
      end
    endfunction

    function void check_word(bit [63:0] word, bit [1:0] idx, bit last);
      root_word_t r;
      if (expected_roots.size() == 0) begin
        errors++;
        $display("%0t: unexpected root word %h idx %0d last %0b", $time, word, idx, last);
        return;
      end
      r = expected_roots.pop_front();
      if (word !== r.word) begin
        errors++;
        $display("%0t: root_word exp %h got %h", $time, r.word, word);
      end
      if (idx !== r.idx) begin
        errors++;
        $display("%0t: root_word_index exp %0d got %0d", $time, r.idx, idx);
      end
      if (last !== r.last) begin
        errors++;
        $display("%0t: last_word exp %0b got %0b", $time, r.last, last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = mrf_pkg::CMD_LEAF;
  logic [1:0]  in_word_index = '0;
  logic [63:0] in_hash_word = '0;
  logic        in_end_of_branch = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_root_word;
  logic [1:0]  out_root_word_index;
  logic        out_last_word;

  root_scoreboard sb = new();
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  merkle_root_fold_sha256d_top uut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_word(out_root_word, out_root_word_index, out_last_word);
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 60) == 0) recv_burst = ~recv_burst;
      n = recv_burst ? 0 : $urandom_range(0, 16);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(negedge clk);
    end
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_word(bit cmd, bit [1:0] idx, bit [63:0] word, bit eob);
    int gap;
    if ($urandom_range(0, 40) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_word_index <= idx;
    in_hash_word <= word;
    in_end_of_branch <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(cmd, idx, word, eob);
    @(negedge clk);
  endtask

  function automatic bit [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // leaf, up to four siblings, then the end flag on word 3 when it is the last word sent
  task automatic send_branch();
    int nsib;
    bit [1:0] order [4];
    nsib = $urandom_range(0, 4);
    order = '{2'd0, 2'd1, 2'd2, 2'd3};
    order.shuffle();
    for (int i = 0; i < 4; i++)
      send_word(mrf_pkg::CMD_LEAF, order[i], rand_word(),
                (order[i] == 2'd3) ? (nsib == 0 && i == 3) : 1'($urandom_range(0, 1)));
    for (int s = 0; s < nsib; s++) begin
      for (int i = 0; i < 3; i++)
        if ($urandom_range(0, 5) != 0)
          send_word(mrf_pkg::CMD_SIBLING, i[1:0], rand_word(), 1'($urandom_range(0, 1)));
      send_word(mrf_pkg::CMD_SIBLING, 2'd3, rand_word(), s == nsib - 1);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // root of an untouched hash is zero
    send_word(mrf_pkg::CMD_LEAF, 2'd3, '0, 1'b1);
    // end flag on words 0..2 is ignored
    send_word(mrf_pkg::CMD_LEAF, 2'd0, '1, 1'b1);
    send_word(mrf_pkg::CMD_LEAF, 2'd1, '0, 1'b1);
    send_word(mrf_pkg::CMD_LEAF, 2'd2, '1, 1'b1);
    send_word(mrf_pkg::CMD_LEAF, 2'd3, '1, 1'b1);
    send_word(mrf_pkg::CMD_SIBLING, 2'd0, '1, 1'b0);
    send_word(mrf_pkg::CMD_SIBLING, 2'd1, '0, 1'b1);
    send_word(mrf_pkg::CMD_SIBLING, 2'd2, '1, 1'b0);
    send_word(mrf_pkg::CMD_SIBLING, 2'd3, '0, 1'b1);
    // fold without end flag, then fold on stale sibling words
    send_word(mrf_pkg::CMD_SIBLING, 2'd3, '1, 1'b0);
    send_word(mrf_pkg::CMD_SIBLING, 2'd3, 64'h0123456789abcdef, 1'b1);
    send_word(mrf_pkg::CMD_LEAF, 2'd0, 64'h8000000000000001, 1'b0);
    send_word(mrf_pkg::CMD_LEAF, 2'd3, 64'h7fffffffffffffff, 1'b1);
    send_word(mrf_pkg::CMD_LEAF, 2'd3, '0, 1'b1);
    while (sb.words_in < 480) begin
      if ($urandom_range(0, 9) == 0)
        send_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_word(),
                  1'($urandom_range(0, 1)));
      else
        send_branch();
    end
    in_valid <= 1'b0;
    while (sb.expected_roots.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("words sent %0d, folds %0d, roots emitted %0d",
             sb.words_in, sb.folds, sb.roots);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
